/* hdl/rtf_pkg.sv */
// Package for the rope tension force block: payload structs, sideband
// structs, register indexes and datapath widths. No dependencies.
package rtf_pkg;

    localparam int MAG_W  = 33;
    localparam int SQ_W   = 66;
    localparam int RAD_W  = 68;
    localparam int ROOT_W = 35;
    localparam int LEN_W  = 31;
    localparam int STIF_W = 16;
    localparam int GAIN_W = 51;
    localparam int GLO_W  = 26;
    localparam int PROD_W = 84;
    localparam int QUO_W  = 50;
    localparam int OUT_W  = 48;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic CFG_ROPE_LENGTH = 1'b0;
    localparam logic CFG_STIFFNESS   = 1'b1;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] force_x;
        logic signed [OUT_W-1:0] force_y;
        logic signed [OUT_W-1:0] force_z;
        logic                    taut;
    } t_out;

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } t_sq_side;

    typedef struct packed {
        logic [2:0] neg;
        logic       kill;
        logic       taut;
    } t_dv_side;

endpackage

/* hdl/rtf_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Depends on rtf_pkg; carries a sideband struct alongside the radicand.
module rtf_sqrt
    import rtf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_sq_side          i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_sq_side          o_side
);

    localparam int PAD_W = 2 * ROOT_W;

    logic              w_v    [0:ROOT_W];
    logic [PAD_W-1:0]  w_rad  [0:ROOT_W];
    logic [ROOT_W:0]   w_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] w_root [0:ROOT_W];
    t_sq_side          w_side [0:ROOT_W];

    assign w_v[0]    = i_valid;
    assign w_rad[0]  = {{(PAD_W-RAD_W){1'b0}}, i_rad};
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              r_v;
        logic [PAD_W-1:0]  r_rad;
        logic [ROOT_W:0]   r_rem;
        logic [ROOT_W-1:0] r_root;
        t_sq_side          r_side;
        logic [ROOT_W+2:0] w_cur;
        logic [ROOT_W+2:0] w_trial;
        logic              w_ge;

        assign w_cur   = {w_rem[k], w_rad[k][PAD_W-1-2*k -: 2]};
        assign w_trial = {1'b0, w_root[k], 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad  <= w_rad[k];
                r_side <= w_side[k];
                r_rem  <= w_ge ? (ROOT_W+1)'(w_cur - w_trial)
                               : w_cur[ROOT_W:0];
                r_root <= {w_root[k][ROOT_W-2:0], w_ge};
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_rad[k+1]  = r_rad;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[ROOT_W];
    assign o_root  = w_root[ROOT_W];
    assign o_side  = w_side[ROOT_W];

endmodule

/* hdl/rtf_div.sv */
// Pipelined restoring divider for three numerators over one shared divisor,
// one quotient bit per register stage. Depends on rtf_pkg.
module rtf_div
    import rtf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2:0][PROD_W-1:0] i_num,
    input  logic [ROOT_W-1:0]      i_den,
    input  t_dv_side               i_side,
    output logic                   o_valid,
    output logic [2:0][QUO_W-1:0]  o_quo,
    output t_dv_side               o_side
);

    logic                   w_v    [0:QUO_W];
    logic [2:0][PROD_W-1:0] w_num  [0:QUO_W];
    logic [2:0][ROOT_W-1:0] w_rem  [0:QUO_W];
    logic [2:0][QUO_W-1:0]  w_quo  [0:QUO_W];
    logic [ROOT_W-1:0]      w_den  [0:QUO_W];
    t_dv_side               w_side [0:QUO_W];

    assign w_v[0]    = i_valid;
    assign w_num[0]  = i_num;
    assign w_quo[0]  = '0;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;
    for (genvar l = 0; l < 3; l++) begin : g_init
        assign w_rem[0][l] = {1'b0, i_num[l][PROD_W-1:QUO_W]};
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic                   r_v;
        logic [2:0][PROD_W-1:0] r_num;
        logic [2:0][ROOT_W-1:0] r_rem;
        logic [2:0][QUO_W-1:0]  r_quo;
        logic [ROOT_W-1:0]      r_den;
        t_dv_side               r_side;
        logic [2:0][ROOT_W-1:0] n_rem;
        logic [2:0][QUO_W-1:0]  n_quo;

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                logic [ROOT_W:0] cur;
                cur = {w_rem[k][l], w_num[k][l][QUO_W-1-k]};
                if (cur >= {1'b0, w_den[k]}) begin
                    n_rem[l] = ROOT_W'(cur - {1'b0, w_den[k]});
                    n_quo[l] = {w_quo[k][l][QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[l] = cur[ROOT_W-1:0];
                    n_quo[l] = {w_quo[k][l][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num  <= w_num[k];
                r_rem  <= n_rem;
                r_quo  <= n_quo;
                r_den  <= w_den[k];
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_num[k+1]  = r_num;
        assign w_rem[k+1]  = r_rem;
        assign w_quo[k+1]  = r_quo;
        assign w_den[k+1]  = r_den;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[QUO_W];
    assign o_quo   = w_quo[QUO_W];
    assign o_side  = w_side[QUO_W];

endmodule

/* hdl/rope_tension_force_top.sv */
// Top level of the rope tension force block: input stages, squares, root,
// gain and products, divider and saturating output register.
// Depends on rtf_pkg, rtf_sqrt and rtf_div.
//
// The block accepts one endpoint pair per cycle while the output side does not
// stall and returns one force request per pair, in order, through the 35-stage
// square root and the 50-stage divider, with eight further register stages
// around them. Any stall on the output holds the whole pipeline.
module rope_tension_force_top
    import rtf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [30:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out_data
);

    logic [LEN_W-1:0]  r_len;
    logic [STIF_W-1:0] r_stiff;
    logic              w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_W'(65536);
            r_stiff <= STIF_W'(100);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ROPE_LENGTH: r_len   <= i_cfg_wdata[LEN_W-1:0];
                CFG_STIFFNESS:   r_stiff <= i_cfg_wdata[STIF_W-1:0];
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    logic [2:0][31:0] w_p1, w_p2;
    assign w_p1 = {i_in_data.first_x, i_in_data.first_y, i_in_data.first_z};
    assign w_p2 = {i_in_data.second_x, i_in_data.second_y, i_in_data.second_z};

    logic                  r1_v;
    t_sq_side              r1_side;
    t_sq_side              n1_side;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [MAG_W-1:0] dl;
            dl = {w_p2[k][31], w_p2[k]} - {w_p1[k][31], w_p1[k]};
            n1_side.neg[k] = dl[MAG_W-1];
            n1_side.mag[k] = dl[MAG_W-1] ? (~dl + 1'b1) : dl;
        end
    end

    logic                  r2_v;
    t_sq_side              r2_side;
    logic [2:0][SQ_W-1:0]  r2_sq;

    logic                  r3_v;
    t_sq_side              r3_side;
    logic [RAD_W-1:0]      r3_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_side <= n1_side;
            r2_side <= r1_side;
            for (int k = 0; k < 3; k++) begin
                r2_sq[k] <= SQ_W'(r1_side.mag[k]) * SQ_W'(r1_side.mag[k]);
            end
            r3_side <= r2_side;
            r3_sum  <= RAD_W'(r2_sq[0]) + RAD_W'(r2_sq[1]) + RAD_W'(r2_sq[2]);
        end
    end

    logic              w_sq_v;
    logic [ROOT_W-1:0] w_root;
    t_sq_side          w_sq_side;

    rtf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r3_v),
        .i_rad   (r3_sum),
        .i_side  (r3_side),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    logic              w_taut;
    assign w_taut = (w_root >= {{(ROOT_W-LEN_W){1'b0}}, r_len});

    logic                   r4_v, r5_v, r6_v, r7_v;
    logic [2:0][MAG_W-1:0]  r4_mag, r5_mag;
    logic [ROOT_W-1:0]      r4_d, r5_d, r6_d, r7_d;
    logic [ROOT_W-1:0]      r4_diff;
    t_dv_side               r4_side, r5_side, r6_side, r7_side;
    logic [GAIN_W-1:0]      r5_gain;
    logic [2:0][GLO_W+MAG_W-1:0]          r6_lo;
    logic [2:0][GAIN_W-GLO_W+MAG_W-1:0]   r6_hi;
    logic [2:0][PROD_W-1:0] r7_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (w_adv) begin
            r4_v <= w_sq_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_mag       <= w_sq_side.mag;
            r4_d         <= w_root;
            r4_diff      <= w_root - {{(ROOT_W-LEN_W){1'b0}}, r_len};
            r4_side.neg  <= w_sq_side.neg;
            r4_side.taut <= w_taut;
            r4_side.kill <= !w_taut || (w_root == '0);

            r5_mag  <= r4_mag;
            r5_d    <= r4_d;
            r5_side <= r4_side;
            r5_gain <= GAIN_W'(r_stiff) * GAIN_W'(r4_diff);

            r6_d    <= r5_d;
            r6_side <= r5_side;
            for (int k = 0; k < 3; k++) begin
                r6_lo[k] <= (GLO_W+MAG_W)'(r5_gain[GLO_W-1:0])
                          * (GLO_W+MAG_W)'(r5_mag[k]);
                r6_hi[k] <= (GAIN_W-GLO_W+MAG_W)'(r5_gain[GAIN_W-1:GLO_W])
                          * (GAIN_W-GLO_W+MAG_W)'(r5_mag[k]);
            end

            r7_d    <= r6_d;
            r7_side <= r6_side;
            for (int k = 0; k < 3; k++) begin
                r7_prod[k] <= PROD_W'(r6_lo[k])
                            + {r6_hi[k][PROD_W-GLO_W-1:0], {GLO_W{1'b0}}};
            end
        end
    end

    logic                  w_dv_v;
    logic [2:0][QUO_W-1:0] w_quo;
    t_dv_side              w_dv_side;

    rtf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r7_v),
        .i_num   (r7_prod),
        .i_den   (r7_d),
        .i_side  (r7_side),
        .o_valid (w_dv_v),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    logic [2:0][OUT_W-1:0] n_force;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (w_dv_side.kill) begin
                n_force[k] = '0;
            end else if (w_dv_side.neg[k]) begin
                if (w_quo[k] > QUO_W'(OUT_MIN)) begin
                    n_force[k] = OUT_MIN;
                end else begin
                    n_force[k] = OUT_W'(~w_quo[k] + 1'b1);
                end
            end else if (w_quo[k] > QUO_W'(OUT_MAX)) begin
                n_force[k] = OUT_MAX;
            end else begin
                n_force[k] = w_quo[k][OUT_W-1:0];
            end
        end
    end

    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.force_x <= n_force[2];
            r_out.force_y <= n_force[1];
            r_out.force_z <= n_force[0];
            r_out.taut    <= w_dv_side.taut;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
